### sv/lnr_pkg.sv
// ============================================================================
// Line rasterizer package
// Shared constants and types for the line rasterizer and its checker.
// ============================================================================
package lnr_pkg;

    // Field widths fixed by the pixel and register formats.
    localparam int ADDR_W     = 26;
    localparam int SW_W       = 13;
    localparam int BPP_W      = 3;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    // Register reset values.
    localparam logic [SW_W-1:0]  SW_RESET  = 13'd1024;
    localparam logic [BPP_W-1:0] BPP_RESET = 3'd4;

    // Command codes carried on the input tuser.
    typedef enum logic [0:0] {
        CMD_START   = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH    = 1'b0,
        REG_BYTES_PER_PIXEL = 1'b1
    } cfg_reg_t;

    // Line colour as latched on a start command.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } color_t;

    // Status of the pixel produced by the walker in the current cycle.
    typedef struct packed {
        logic emit;
        logic last;
        logic target;
    } pix_flags_t;

endpackage

### sv/lnr_walker.sv
// ============================================================================
// Line walker
// Holds the line state and steps it one pixel per advance on an active line,
// tracking the minor coordinate with an exact integer error term.
// ============================================================================
module lnr_walker #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    take,
    input  lnr_pkg::cmd_t           cmd,
    input  logic [COORD_WIDTH-1:0]  start_x,
    input  logic [COORD_WIDTH-1:0]  start_y,
    input  logic [COORD_WIDTH-1:0]  end_x,
    input  logic [COORD_WIDTH-1:0]  end_y,
    input  lnr_pkg::color_t         color_in,
    input  logic                    target_in,
    output logic [COORD_WIDTH-1:0]  pix_x,
    output logic [COORD_WIDTH-1:0]  pix_y,
    output lnr_pkg::color_t         pix_color,
    output lnr_pkg::pix_flags_t     pix_flags
);

    localparam int ERR_W = COORD_WIDTH + 2;

    // Line state.
    logic                    active_reg, active_next;
    logic                    major_x_reg, major_x_next;
    logic [COORD_WIDTH-1:0]  major_now_reg, major_now_next;
    logic [COORD_WIDTH-1:0]  major_stop_reg, major_stop_next;
    logic [COORD_WIDTH-1:0]  minor_now_reg, minor_now_next;
    logic                    descends_reg, descends_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [COORD_WIDTH-1:0]  major_span_reg, major_span_next;
    logic [COORD_WIDTH-1:0]  minor_span_reg, minor_span_next;
    lnr_pkg::color_t         color_reg, color_next;
    logic                    target_reg, target_next;

    // Start command set-up terms.
    logic [COORD_WIDTH-1:0]  dx, dy;
    logic                    new_major_x;
    logic [COORD_WIDTH-1:0]  ma1, mi1, ma2, mi2;
    logic [COORD_WIDTH-1:0]  lo_major, hi_major, lo_minor, hi_minor;

    // Step terms.
    logic                    at_last;
    logic                    advance;
    logic signed [ERR_W-1:0] minor_s, major_s, err_up, err_dn;

    // Endpoint ordering for a start command.
    always_comb
    begin
        dx          = (start_x > end_x) ? (start_x - end_x) : (end_x - start_x);
        dy          = (start_y > end_y) ? (start_y - end_y) : (end_y - start_y);
        new_major_x = dx > dy;
        ma1         = new_major_x ? start_x : start_y;
        mi1         = new_major_x ? start_y : start_x;
        ma2         = new_major_x ? end_x   : end_y;
        mi2         = new_major_x ? end_y   : end_x;
        if (ma1 > ma2)
        begin
            lo_major = ma2;
            hi_major = ma1;
            lo_minor = mi2;
            hi_minor = mi1;
        end
        else
        begin
            lo_major = ma1;
            hi_major = ma2;
            lo_minor = mi1;
            hi_minor = mi2;
        end
    end

    // Error term candidates for one step along the major axis.
    assign minor_s = $signed({2'b00, minor_span_reg});
    assign major_s = $signed({2'b00, major_span_reg});
    assign err_up  = err_reg + minor_s;
    assign err_dn  = err_reg - minor_s;
    assign at_last = major_now_reg == major_stop_reg;
    assign advance = take && (cmd == lnr_pkg::CMD_ADVANCE) && active_reg;

    // Next-state selection.
    always_comb
    begin
        active_next     = active_reg;
        major_x_next    = major_x_reg;
        major_now_next  = major_now_reg;
        major_stop_next = major_stop_reg;
        minor_now_next  = minor_now_reg;
        descends_next   = descends_reg;
        err_next        = err_reg;
        major_span_next = major_span_reg;
        minor_span_next = minor_span_reg;
        color_next      = color_reg;
        target_next     = target_reg;
        if (take && (cmd == lnr_pkg::CMD_START))
        begin
            active_next     = 1'b1;
            major_x_next    = new_major_x;
            major_now_next  = lo_major;
            major_stop_next = hi_major;
            minor_now_next  = lo_minor;
            descends_next   = hi_minor < lo_minor;
            err_next        = '0;
            major_span_next = hi_major - lo_major;
            minor_span_next = (hi_minor > lo_minor) ? (hi_minor - lo_minor)
                                                    : (lo_minor - hi_minor);
            color_next      = color_in;
            target_next     = target_in;
        end
        else if (advance)
        begin
            if (at_last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                major_now_next = major_now_reg + 1'b1;
                if (!descends_reg)
                begin
                    if (err_up >= major_s)
                    begin
                        err_next       = err_up - major_s;
                        minor_now_next = minor_now_reg + 1'b1;
                    end
                    else
                    begin
                        err_next = err_up;
                    end
                end
                else
                begin
                    if (err_dn < 0)
                    begin
                        err_next       = err_dn + major_s;
                        minor_now_next = minor_now_reg - 1'b1;
                    end
                    else
                    begin
                        err_next = err_dn;
                    end
                end
            end
        end
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            major_x_reg    <= 1'b0;
            major_now_reg  <= '0;
            major_stop_reg <= '0;
            minor_now_reg  <= '0;
            descends_reg   <= 1'b0;
            err_reg        <= '0;
            major_span_reg <= '0;
            minor_span_reg <= '0;
            color_reg      <= '0;
            target_reg     <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            major_x_reg    <= major_x_next;
            major_now_reg  <= major_now_next;
            major_stop_reg <= major_stop_next;
            minor_now_reg  <= minor_now_next;
            descends_reg   <= descends_next;
            err_reg        <= err_next;
            major_span_reg <= major_span_next;
            minor_span_reg <= minor_span_next;
            color_reg      <= color_next;
            target_reg     <= target_next;
        end
    end

    // Pixel at the current position.
    assign pix_x            = major_x_reg ? major_now_reg : minor_now_reg;
    assign pix_y            = major_x_reg ? minor_now_reg : major_now_reg;
    assign pix_color        = color_reg;
    assign pix_flags.emit   = advance;
    assign pix_flags.last   = at_last;
    assign pix_flags.target = target_reg;

endmodule

### sv/line_rasterizer.sv
// An accepted advance's pixel is registered in the row stage, then in the result
// stage, which presents it on the master side. Start commands give no pixel.
// Throughput: one command per cycle unless a master-side stall fills both stages.
// The row multiply and the final bytes-per-pixel multiply each have their own stage.
// Reset: asynchronous, clears the line (no line active), empties the output stages,
// and sets screen_width to 1024 and bytes_per_pixel to 4.
// ============================================================================
// Line rasterizer
// Streams one pixel, with its byte address, per advance command along a line
// loaded by a start command.
// ============================================================================
module line_rasterizer #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [lnr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lnr_pkg::CFG_DATA_W-1:0]       cfg_data,
    // Command stream.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: start_x, start_y, end_x, end_y, red, green, blue.
    input  logic [((4*COORD_WIDTH+24+7)/8)*8-1:0] s_tdata,
    // Fields from bit 0: command, target_buffer.
    input  logic [1:0]                           s_tuser,
    // Pixel stream.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // Fields from bit 0: pixel_x, pixel_y, byte_address, pixel_red,
    // pixel_green, pixel_blue.
    output logic [((2*COORD_WIDTH+lnr_pkg::ADDR_W+24+7)/8)*8-1:0] m_tdata,
    // Field: pixel_target.
    output logic                                 m_tuser,
    // Field: last_pixel.
    output logic                                 m_tlast
);

    localparam int CW     = COORD_WIDTH;
    localparam int AW     = lnr_pkg::ADDR_W;
    localparam int OUT_W  = ((2*CW+AW+24+7)/8)*8;
    localparam int PROD_W = CW + lnr_pkg::SW_W;

    // Configuration registers.
    logic [lnr_pkg::SW_W-1:0]  sw_reg;
    logic [lnr_pkg::BPP_W-1:0] bpp_reg;

    // Handshake terms.
    logic b_free, a_free, take;

    // Walker outputs.
    logic [CW-1:0]       w_x, w_y;
    lnr_pkg::color_t     w_color, in_color;
    lnr_pkg::pix_flags_t w_flags;

    // Row stage.
    logic                a_valid_reg, a_valid_next;
    logic [CW-1:0]       a_x_reg, a_y_reg;
    logic [AW-1:0]       a_prod_reg;
    lnr_pkg::color_t     a_color_reg;
    logic                a_last_reg, a_target_reg;
    logic [PROD_W-1:0]   prod_full;

    // Result stage.
    logic                b_valid_reg, b_valid_next;
    logic [CW-1:0]       b_x_reg, b_y_reg;
    logic [AW-1:0]       b_addr_reg;
    lnr_pkg::color_t     b_color_reg;
    logic                b_last_reg, b_target_reg;
    logic [AW-1:0]       row_sum;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= lnr_pkg::SW_RESET;
            bpp_reg <= lnr_pkg::BPP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lnr_pkg::cfg_reg_t'(cfg_index))
                lnr_pkg::REG_SCREEN_WIDTH:    sw_reg  <= cfg_data;
                lnr_pkg::REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[lnr_pkg::BPP_W-1:0];
                default:                      sw_reg  <= sw_reg;
            endcase
        end
    end

    // A command is taken whenever the row stage can accept a pixel.
    assign b_free   = !b_valid_reg || m_tready;
    assign a_free   = !a_valid_reg || b_free;
    assign s_tready = a_free;
    assign take     = s_tvalid && s_tready;

    assign in_color.red   = s_tdata[4*CW+7:4*CW];
    assign in_color.green = s_tdata[4*CW+15:4*CW+8];
    assign in_color.blue  = s_tdata[4*CW+23:4*CW+16];

    lnr_walker #(
        .COORD_WIDTH(CW)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .cmd       (lnr_pkg::cmd_t'(s_tuser[0])),
        .start_x   (s_tdata[CW-1:0]),
        .start_y   (s_tdata[2*CW-1:CW]),
        .end_x     (s_tdata[3*CW-1:2*CW]),
        .end_y     (s_tdata[4*CW-1:3*CW]),
        .color_in  (in_color),
        .target_in (s_tuser[1]),
        .pix_x     (w_x),
        .pix_y     (w_y),
        .pix_color (w_color),
        .pix_flags (w_flags)
    );

    // Row stage: y times screen width.
    assign prod_full    = PROD_W'(w_y) * PROD_W'(sw_reg);
    assign a_valid_next = a_free ? w_flags.emit : a_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_free && w_flags.emit)
        begin
            a_x_reg      <= w_x;
            a_y_reg      <= w_y;
            a_prod_reg   <= AW'(prod_full);
            a_color_reg  <= w_color;
            a_last_reg   <= w_flags.last;
            a_target_reg <= w_flags.target;
        end
    end

    // Result stage: add x and scale by bytes per pixel, wrapped to the address width.
    assign row_sum      = a_prod_reg + AW'(a_x_reg);
    assign b_valid_next = b_free ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_free && a_valid_reg)
        begin
            b_x_reg      <= a_x_reg;
            b_y_reg      <= a_y_reg;
            b_addr_reg   <= row_sum * AW'(bpp_reg);
            b_color_reg  <= a_color_reg;
            b_last_reg   <= a_last_reg;
            b_target_reg <= a_target_reg;
        end
    end

    // Pixel stream outputs.
    assign m_tvalid = b_valid_reg;
    assign m_tdata  = OUT_W'({b_color_reg.blue, b_color_reg.green, b_color_reg.red,
                              b_addr_reg, b_y_reg, b_x_reg});
    assign m_tuser  = b_target_reg;
    assign m_tlast  = b_last_reg;

endmodule

### sv/lnr_checker.sv
// ============================================================================
// Line rasterizer checker
// Port-level assertions on the command and pixel streams, bound to the top level.
// ============================================================================
module lnr_checker #(
    parameter int COORD_WIDTH = 12
) (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_we,
    input logic [lnr_pkg::CFG_IDX_W-1:0]        cfg_index,
    input logic [lnr_pkg::CFG_DATA_W-1:0]       cfg_data,
    input logic                                 s_tready,
    input logic                                 m_tvalid,
    input logic                                 m_tready,
    input logic [((2*COORD_WIDTH+lnr_pkg::ADDR_W+24+7)/8)*8-1:0] m_tdata,
    input logic                                 m_tuser,
    input logic                                 m_tlast
);

    localparam int CW = COORD_WIDTH;
    localparam int AW = lnr_pkg::ADDR_W;

    // Shadow copies of the configuration registers.
    logic [lnr_pkg::SW_W-1:0]  sw_reg;
    logic [lnr_pkg::BPP_W-1:0] bpp_reg;
    logic [63:0]               expected_addr;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= lnr_pkg::SW_RESET;
            bpp_reg <= lnr_pkg::BPP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (lnr_pkg::cfg_reg_t'(cfg_index))
                lnr_pkg::REG_SCREEN_WIDTH:    sw_reg  <= cfg_data;
                lnr_pkg::REG_BYTES_PER_PIXEL: bpp_reg <= cfg_data[lnr_pkg::BPP_W-1:0];
                default:                      sw_reg  <= sw_reg;
            endcase
        end
    end

    assign expected_addr = (64'(m_tdata[2*CW-1:CW]) * 64'(sw_reg) + 64'(m_tdata[CW-1:0]))
                           * 64'(bpp_reg);

    // The output stages are empty while reset is held.
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("pixel stream valid during reset");

    // A stalled pixel holds its payload.
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                   && $stable(m_tuser))
        else $error("stalled pixel changed");

    // Commands are refused only while a pixel waits on the master side.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("command refused without downstream stall");

    // The byte address agrees with the coordinates and the registers.
    a_address: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2*CW+AW-1:2*CW] == expected_addr[AW-1:0])
        else $error("byte address mismatch");

endmodule

bind line_rasterizer lnr_checker #(.COORD_WIDTH(COORD_WIDTH)) u_lnr_checker (.*);

### sim/tb.sv
// ============================================================================
// Line rasterizer testbench
// Sends start and advance commands to the rasterizer and checks every pixel
// against a line walker kept in step with the commands the block accepts.
// Directed lines cover single pixels, ties, falling minor axes and replaced
// lines. Random lines then run under several register settings, with and
// without idle cycles on either side.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_W     = 12;
    localparam int S_DATA_W    = ((4*COORD_W+24+7)/8)*8;
    localparam int M_DATA_W    = ((2*COORD_W+lnr_pkg::ADDR_W+24+7)/8)*8;
    localparam int HOLD_OFF    = 4;
    localparam int STALL_LIMIT = 4000;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;

    // One command as carried on the slave side.
    typedef struct {
        lnr_pkg::cmd_t      cmd;
        logic [COORD_W-1:0] start_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] end_y;
        lnr_pkg::color_t    color;
        logic               target;
    } command_t;

    // One pixel as expected on the master side.
    typedef struct {
        logic [COORD_W-1:0]         x;
        logic [COORD_W-1:0]         y;
        logic [lnr_pkg::ADDR_W-1:0] addr;
        lnr_pkg::color_t            color;
        logic                       target;
        logic                       last;
    } pixel_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we     = 1'b0;
    logic [lnr_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [lnr_pkg::CFG_DATA_W-1:0] cfg_data   = '0;
    logic                           s_tvalid   = 1'b0;
    logic                           s_tready;
    logic [S_DATA_W-1:0]            s_tdata    = '0;
    logic [1:0]                     s_tuser    = '0;
    logic                           m_tvalid;
    logic                           m_tready   = 1'b0;
    logic [M_DATA_W-1:0]            m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int error_count        = 0;

    // Register copies and line walker state.
    logic [lnr_pkg::SW_W-1:0]  screen_w = lnr_pkg::SW_RESET;
    logic [lnr_pkg::BPP_W-1:0] bytes_pp = lnr_pkg::BPP_RESET;
    logic               walk_active;
    logic               walk_major_x;
    logic [COORD_W-1:0] walk_pos;
    logic [COORD_W-1:0] walk_stop;
    logic [COORD_W-1:0] walk_minor;
    logic               walk_minor_down;
    int                 walk_error;
    int                 walk_major_span;
    int                 walk_minor_span;
    lnr_pkg::color_t    walk_color;
    logic               walk_target;

    pixel_t expected_pixels[$];

    line_rasterizer #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The receiver stalls at random according to the current phase.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    // Walks the line one step per advance, exactly as the block should.
    function automatic void predict_command(input command_t c);
        logic [COORD_W-1:0] ma1, mi1, ma2, mi2, tmp;
        int                 dx, dy;
        pixel_t             px;
        longint unsigned    addr;

        if (c.cmd == lnr_pkg::CMD_START)
        begin
            dx = (c.start_x > c.end_x) ? c.start_x - c.end_x : c.end_x - c.start_x;
            dy = (c.start_y > c.end_y) ? c.start_y - c.end_y : c.end_y - c.start_y;
            walk_major_x = dx > dy;
            if (walk_major_x)
            begin
                ma1 = c.start_x; mi1 = c.start_y; ma2 = c.end_x; mi2 = c.end_y;
            end
            else
            begin
                ma1 = c.start_y; mi1 = c.start_x; ma2 = c.end_y; mi2 = c.end_x;
            end
            if (ma1 > ma2)
            begin
                tmp = ma1; ma1 = ma2; ma2 = tmp;
                tmp = mi1; mi1 = mi2; mi2 = tmp;
            end
            walk_pos        = ma1;
            walk_stop       = ma2;
            walk_minor      = mi1;
            walk_minor_down = mi2 < mi1;
            walk_major_span = ma2 - ma1;
            walk_minor_span = (mi1 > mi2) ? mi1 - mi2 : mi2 - mi1;
            walk_error      = 0;
            walk_color      = c.color;
            walk_target     = c.target;
            walk_active     = 1'b1;
            return;
        end

        // An advance with no line in progress is ignored.
        if (!walk_active)
            return;

        px.x      = walk_major_x ? walk_pos : walk_minor;
        px.y      = walk_major_x ? walk_minor : walk_pos;
        addr      = (longint'(px.y) * longint'(screen_w) + longint'(px.x))
                    * longint'(bytes_pp);
        px.addr   = addr[lnr_pkg::ADDR_W-1:0];
        px.color  = walk_color;
        px.target = walk_target;
        px.last   = (walk_pos == walk_stop);
        expected_pixels.push_back(px);

        if (px.last)
        begin
            walk_active = 1'b0;
        end
        else
        begin
            walk_pos = walk_pos + 1'b1;
            if (!walk_minor_down)
            begin
                walk_error += walk_minor_span;
                if (walk_error >= walk_major_span)
                begin
                    walk_error -= walk_major_span;
                    walk_minor = walk_minor + 1'b1;
                end
            end
            else
            begin
                walk_error -= walk_minor_span;
                if (walk_error < 0)
                begin
                    walk_error += walk_major_span;
                    walk_minor = walk_minor - 1'b1;
                end
            end
        end
    endfunction

    // Each pixel transaction is checked against the oldest expected pixel.
    always @(posedge clk)
    begin : pixel_checker
        pixel_t want;

        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pixels.size() == 0)
            begin
                report_mismatch($sformatf("pixel (%0d,%0d) with none expected",
                                          m_tdata[11:0], m_tdata[23:12]));
            end
            else
            begin
                want = expected_pixels.pop_front();
                if (m_tdata[11:0] !== want.x)
                    report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                              m_tdata[11:0], want.x));
                if (m_tdata[23:12] !== want.y)
                    report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                              m_tdata[23:12], want.y));
                if (m_tdata[49:24] !== want.addr)
                    report_mismatch($sformatf("byte_address got %0d expected %0d",
                                              m_tdata[49:24], want.addr));
                if (m_tdata[57:50] !== want.color.red)
                    report_mismatch($sformatf("pixel_red got %0d expected %0d",
                                              m_tdata[57:50], want.color.red));
                if (m_tdata[65:58] !== want.color.green)
                    report_mismatch($sformatf("pixel_green got %0d expected %0d",
                                              m_tdata[65:58], want.color.green));
                if (m_tdata[73:66] !== want.color.blue)
                    report_mismatch($sformatf("pixel_blue got %0d expected %0d",
                                              m_tdata[73:66], want.color.blue));
                if (m_tdata[M_DATA_W-1:74] !== '0)
                    report_mismatch($sformatf("tdata padding got %0h",
                                              m_tdata[M_DATA_W-1:74]));
                if (m_tuser !== want.target)
                    report_mismatch($sformatf("pixel_target got %0b expected %0b",
                                              m_tuser, want.target));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last_pixel got %0b expected %0b",
                                              m_tlast, want.last));
            end
        end
    end

    // The run ends if no transaction happens on either side for too long.
    initial
    begin : watchdog
        int quiet_cycles;

        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb failed");
        $finish;
    end

    // Sends one command, idling first at random, and predicts it once accepted.
    task automatic send_command(input command_t c);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {c.color.blue, c.color.green, c.color.red,
                     c.end_y, c.end_x, c.start_y, c.start_x};
        s_tuser  <= {c.target, c.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        predict_command(c);
    endtask

    // Holds the sender until every expected pixel has arrived, then lets the
    // pipeline settle.
    task automatic drain_pixels();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    task automatic write_register(input lnr_pkg::cfg_reg_t idx,
                                  input logic [lnr_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        if (idx == lnr_pkg::REG_SCREEN_WIDTH)
            screen_w = value[lnr_pkg::SW_W-1:0];
        else
            bytes_pp = value[lnr_pkg::BPP_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_frame_format(input logic [lnr_pkg::CFG_DATA_W-1:0] width,
                                    input logic [lnr_pkg::CFG_DATA_W-1:0] bpp);
        drain_pixels();
        write_register(lnr_pkg::REG_SCREEN_WIDTH, width);
        write_register(lnr_pkg::REG_BYTES_PER_PIXEL, bpp);
    endtask

    function automatic command_t random_command(input lnr_pkg::cmd_t kind);
        command_t c;

        c.cmd         = kind;
        c.start_x     = COORD_W'($urandom_range(COORD_MAX));
        c.start_y     = COORD_W'($urandom_range(COORD_MAX));
        c.end_x       = COORD_W'($urandom_range(COORD_MAX));
        c.end_y       = COORD_W'($urandom_range(COORD_MAX));
        c.color.red   = 8'($urandom_range(255));
        c.color.green = 8'($urandom_range(255));
        c.color.blue  = 8'($urandom_range(255));
        c.target      = 1'($urandom_range(1));
        return c;
    endfunction

    function automatic command_t line_command(input int sx, input int sy,
                                              input int ex, input int ey,
                                              input int rgb, input logic target);
        command_t c;

        c         = random_command(lnr_pkg::CMD_START);
        c.start_x = COORD_W'(sx);
        c.start_y = COORD_W'(sy);
        c.end_x   = COORD_W'(ex);
        c.end_y   = COORD_W'(ey);
        c.color   = rgb[23:0];
        c.target  = target;
        return c;
    endfunction

    // A coordinate within reach of base, clipped to the screen.
    function automatic logic [COORD_W-1:0] near_coord(input logic [COORD_W-1:0] base,
                                                      input int reach);
        int v;

        v = int'(base) + int'($urandom_range(2*reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return COORD_W'(v);
    endfunction

    task automatic send_advances(input int count);
        repeat (count) send_command(random_command(lnr_pkg::CMD_ADVANCE));
    endtask

    task automatic test_advance_when_idle();
        send_advances(1);
    endtask

    // Equal endpoints at both corners of the screen; the second advance
    // after the lone pixel finds no line.
    task automatic test_single_pixel_lines();
        send_command(line_command(0, 0, 0, 0, 24'h000000, 1'b0));
        send_advances(2);
        send_command(line_command(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                  24'hFFFFFF, 1'b1));
        send_advances(1);
    endtask

    // Equal spans on both axes make y the major axis.
    task automatic test_diagonal_tie();
        send_command(line_command(COORD_MAX, 0, COORD_MAX-2, 2, 24'h12A5F0, 1'b1));
        send_advances(3);
    endtask

    task automatic test_descending_minor();
        send_command(line_command(0, COORD_MAX, 3, COORD_MAX-1, 24'h5A0FC3, 1'b0));
        send_advances(4);
    endtask

    // A start in the middle of a line drops the rest of it; the new line
    // has its endpoints given in falling order.
    task automatic test_line_replacement();
        send_command(line_command(10, 10, 20, 30, 24'h808080, 1'b0));
        send_advances(2);
        send_command(line_command(100, 50, 95, 52, 24'h7F017E, 1'b1));
        send_advances(6);
    endtask

    // Mostly complete lines with random content, some cut short or
    // overrun, and a few stray advances.
    task automatic test_random_lines(input int n_items, input int idle_pct,
                                     input int stall_pct, input bit pause_midway);
        command_t c;
        int       sent, pick, reach, dx, dy, span, n_adv, next_pause;

        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        sent       = 0;
        next_pause = 150;
        while (sent < n_items)
        begin
            if (pause_midway && sent >= next_pause)
            begin
                drain_pixels();
                next_pause += 150;
            end
            if ($urandom_range(99) < 8)
            begin
                send_advances(1);
                sent++;
            end
            else
            begin
                c    = random_command(lnr_pkg::CMD_START);
                pick = $urandom_range(99);
                reach = (pick < 70) ? 8 : (pick < 95) ? 48 : 0;
                if (reach != 0)
                begin
                    c.end_x = near_coord(c.start_x, reach);
                    c.end_y = near_coord(c.start_y, reach);
                end
                dx   = (c.start_x > c.end_x) ? c.start_x - c.end_x : c.end_x - c.start_x;
                dy   = (c.start_y > c.end_y) ? c.start_y - c.end_y : c.end_y - c.start_y;
                span = ((dx > dy) ? dx : dy) + 1;
                if (span > 64)
                    n_adv = $urandom_range(24, 1);
                else if ($urandom_range(9) == 0)
                    n_adv = $urandom_range(span-1, 0);
                else
                    n_adv = span + (($urandom_range(4) == 0) ? $urandom_range(2, 1) : 0);
                send_command(c);
                send_advances(n_adv);
                sent += 1 + n_adv;
            end
        end
    endtask

    // Register values outside the documented range wrap the address.
    task automatic test_out_of_range_registers();
        set_frame_format(13'h1FFF, 3'd7);
        test_random_lines(60, 0, 0, 1'b0);
        set_frame_format(13'd0, 3'd0);
        test_random_lines(40, 0, 0, 1'b0);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        walk_active = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_advance_when_idle();
        test_single_pixel_lines();
        test_diagonal_tie();
        test_descending_minor();
        test_line_replacement();

        set_frame_format(13'd4096, 3'd3);
        test_random_lines(260, 0, 0, 1'b0);
        set_frame_format(13'd1, 3'd4);
        test_random_lines(260, 53, 0, 1'b0);
        set_frame_format(13'd640, 3'd3);
        test_random_lines(260, 0, 53, 1'b0);
        set_frame_format(13'd4096, 3'd4);
        test_random_lines(260, 34, 34, 1'b1);
        test_out_of_range_registers();

        drain_pixels();
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
